// ----- rtl/cptd_pkg.sv -----
// shared types, codes and match function for the prefix table
`timescale 1ns / 1ps

package cptd_pkg;

  localparam int unsigned ENTRIES_DEF = 64;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned REM_W       = 6;
  localparam int unsigned STATUS_W    = 3;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(32);

  // request function codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LIST   = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED   = 3'd0,
    ST_COVERED = 3'd1,
    ST_FULL    = 3'd2,
    ST_LISTED  = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COVER,
    S_KILL,
    S_LIST,
    S_FINISH
  } state_e;

  // one stored prefix and its live flag
  typedef struct packed {
    logic              live;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
  } entry_t;

  // true when address a lies inside prefix base/len, len 0..32
  function automatic logic prefix_holds(input logic [ADDR_W-1:0] base,
                                        input logic [LEN_W-1:0]  len,
                                        input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] mask;
    mask = ~({ADDR_W{1'b1}} >> len);
    return ((a ^ base) & mask) == '0;
  endfunction

endpackage

// ----- rtl/cidr_prefix_table_dedup_core.sv -----
// top level: prefix table with insert-time deduplication and listing
// n = used slots; a scan pass reads slots 0..n-1, one slot per cycle except
// while a listed entry waits on a stalled output; insert: cover pass, then a kill
// pass only when the prefix is added; the result follows the kill pass when added,
// the cover pass when covered or full; list: live entries stream out one behind
// the scan; next request in the cycle after the final result, output stalls add
// reset clears the slot count and control; stored entries are read only below it
`timescale 1ns / 1ps

module cidr_prefix_table_dedup_core #(
  parameter int unsigned ENTRIES = cptd_pkg::ENTRIES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            func_i,
  input  logic [cptd_pkg::ADDR_W-1:0]     addr_i,
  input  logic [cptd_pkg::LEN_W-1:0]      prefix_len_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [cptd_pkg::STATUS_W-1:0]   status_o,
  output logic [cptd_pkg::ADDR_W-1:0]     entry_addr_out_o,
  output logic [cptd_pkg::LEN_W-1:0]      entry_len_out_o,
  output logic [cptd_pkg::REM_W-1:0]      removed_count_o,
  output logic                            last_o
);
  import cptd_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  // control state
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   used_q, used_d;
  logic [CNT_W-1:0]   j_q, j_d;
  logic [IDX_W-1:0]   rj_q, rj_d;
  logic               rv_q, rv_d;
  logic               cov_q, cov_d;
  logic               any_q, any_d;
  logic [CNT_W-1:0]   rem_q, rem_d;

  // request registers; a list keeps the latest live entry in addr and len
  logic               func_q, func_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [LEN_W-1:0]   len_q, len_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic               out_load;
  status_e            st_q, st_d;
  logic [ADDR_W-1:0]  oaddr_q, oaddr_d;
  logic [LEN_W-1:0]   olen_q, olen_d;
  logic [REM_W-1:0]   orem_q, orem_d;
  logic               olast_q, olast_d;

  // memory port signals
  logic               wr_en;
  logic [IDX_W-1:0]   wr_idx;
  entry_t             wr_data;
  logic               rd_en;
  entry_t             rd_data;

  // scan helpers
  logic               out_free;
  logic               scanning;
  logic               scan_done;
  logic               cov_hit;
  logic               kill_hit;
  logic               list_hit;
  logic               adv;
  logic               full;

  cptd_mem #(
    .ENTRIES (ENTRIES)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_idx_i  (wr_idx),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_idx_i  (j_q[IDX_W-1:0]),
    .rd_data_o (rd_data)
  );

  // evaluation of the entry from the last issued read
  assign out_free  = !out_valid_q || out_ready_i;
  assign scanning  = (state_q == S_COVER) || (state_q == S_KILL) || (state_q == S_LIST);
  assign scan_done = !(j_q < used_q);
  assign cov_hit   = rv_q && rd_data.live && (rd_data.len < len_q) &&
                     prefix_holds(rd_data.addr, rd_data.len, addr_q);
  assign kill_hit  = rv_q && rd_data.live && prefix_holds(addr_q, len_q, rd_data.addr);
  assign list_hit  = rv_q && rd_data.live;
  assign adv       = !((state_q == S_LIST) && list_hit && any_q) || out_free;
  assign full      = (used_q == CNT_W'(ENTRIES));

  // next state and datapath control
  always_comb begin
    state_d  = state_q;
    used_d   = used_q;
    j_d      = j_q;
    rj_d     = rj_q;
    rv_d     = rv_q;
    cov_d    = cov_q;
    any_d    = any_q;
    rem_d    = rem_q;
    func_d   = func_q;
    addr_d   = addr_q;
    len_d    = len_q;
    out_load = 1'b0;
    st_d     = st_q;
    oaddr_d  = oaddr_q;
    olen_d   = olen_q;
    orem_d   = orem_q;
    olast_d  = olast_q;
    wr_en    = 1'b0;
    wr_idx   = used_q[IDX_W-1:0];
    wr_data  = '{live: 1'b1, addr: addr_q, len: len_q};
    rd_en    = 1'b0;
    in_ready_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          func_d  = func_i;
          addr_d  = addr_i;
          len_d   = (prefix_len_i > MAX_LEN) ? MAX_LEN : prefix_len_i;
          j_d     = '0;
          rv_d    = 1'b0;
          cov_d   = 1'b0;
          any_d   = 1'b0;
          rem_d   = '0;
          state_d = (func_i == FUNC_LIST) ? S_LIST : S_COVER;
        end
      end

      S_COVER: begin
        // a live entry with a shorter length that holds the address covers it
        if (cov_hit) begin
          cov_d = 1'b1;
        end
        if (scan_done) begin
          j_d = '0;
          if (cov_d || full) begin
            state_d = S_FINISH;
          end else begin
            state_d = S_KILL;
          end
        end
      end

      S_KILL: begin
        // clear the live flag of every entry inside the new prefix
        if (kill_hit) begin
          wr_en   = 1'b1;
          wr_idx  = rj_q;
          wr_data = '{live: 1'b0, addr: rd_data.addr, len: rd_data.len};
          rem_d   = rem_q + CNT_W'(1);
        end
        if (scan_done) begin
          state_d = S_FINISH;
        end
      end

      S_LIST: begin
        // emit the held entry once a later live one shows it is not last
        if (adv && list_hit) begin
          if (any_q) begin
            out_load = 1'b1;
            st_d     = ST_LISTED;
            oaddr_d  = addr_q;
            olen_d   = len_q;
            orem_d   = '0;
            olast_d  = 1'b0;
          end
          any_d  = 1'b1;
          addr_d = rd_data.addr;
          len_d  = rd_data.len;
        end
        if (adv && scan_done) begin
          state_d = S_FINISH;
        end
      end

      S_FINISH: begin
        if (out_free) begin
          out_load = 1'b1;
          oaddr_d  = addr_q;
          olen_d   = len_q;
          orem_d   = '0;
          olast_d  = 1'b1;
          state_d  = S_IDLE;
          priority if (func_q == FUNC_LIST) begin
            if (any_q) begin
              st_d = ST_LISTED;
            end else begin
              st_d    = ST_EMPTY;
              oaddr_d = '0;
              olen_d  = '0;
            end
          end else if (cov_q) begin
            st_d = ST_COVERED;
          end else if (full) begin
            st_d = ST_FULL;
          end else begin
            st_d   = ST_ADDED;
            orem_d = REM_W'(rem_q);
            wr_en  = 1'b1;
            used_d = used_q + CNT_W'(1);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // scan read pipeline, one slot per cycle while the scan advances
    if (scanning && adv) begin
      if (j_q < used_q) begin
        rd_en = 1'b1;
        rj_d  = j_q[IDX_W-1:0];
        j_d   = j_q + CNT_W'(1);
        rv_d  = 1'b1;
      end else begin
        rv_d = 1'b0;
      end
    end

    // output register handshake
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      rv_q        <= rv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    j_q     <= j_d;
    rj_q    <= rj_d;
    cov_q   <= cov_d;
    any_q   <= any_d;
    rem_q   <= rem_d;
    func_q  <= func_d;
    addr_q  <= addr_d;
    len_q   <= len_d;
    st_q    <= st_d;
    oaddr_q <= oaddr_d;
    olen_q  <= olen_d;
    orem_q  <= orem_d;
    olast_q <= olast_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = st_q;
  assign entry_addr_out_o = oaddr_q;
  assign entry_len_out_o  = olen_q;
  assign removed_count_o  = orem_q;
  assign last_o           = olast_q;

endmodule

// ----- rtl/cptd_mem.sv -----
// prefix storage: one write port, one read port with registered data
`timescale 1ns / 1ps

module cptd_mem #(
  parameter int unsigned ENTRIES = cptd_pkg::ENTRIES_DEF,
  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic [IDX_W-1:0]      wr_idx_i,
  input  cptd_pkg::entry_t      wr_data_i,
  input  logic                  rd_en_i,
  input  logic [IDX_W-1:0]      rd_idx_i,
  output cptd_pkg::entry_t      rd_data_o
);
  import cptd_pkg::*;

  entry_t mem_q [ENTRIES];
  entry_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
  end

  // read port, data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_idx_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/cptd_checker.sv -----
// port-level checks for the prefix table, bound to the top level
`timescale 1ns / 1ps

module cptd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [cptd_pkg::STATUS_W-1:0]   status_o,
  input logic [cptd_pkg::ADDR_W-1:0]     entry_addr_out_o,
  input logic [cptd_pkg::REM_W-1:0]      removed_count_o,
  input logic                            last_o
);
  import cptd_pkg::*;

  // a pending result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(status_o) && $stable(entry_addr_out_o))
    else $error("stalled result changed");

  // one request at a time: ready drops after an accepted request
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  // only listed entries may leave last low
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_LISTED) |-> last_o)
    else $error("single result without last");

  // removals are reported only on an added prefix
  a_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_ADDED) |-> (removed_count_o == '0))
    else $error("removed count on a result that is not an add");

endmodule

bind cidr_prefix_table_dedup_core cptd_checker u_cptd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .status_o         (status_o),
  .entry_addr_out_o (entry_addr_out_o),
  .removed_count_o  (removed_count_o),
  .last_o           (last_o)
);
